@@ src/srr_pkg.sv @@
// shared constants, types and helpers for the sprite row rasterizer
`default_nettype none

package srr_pkg;

   localparam int SCREEN_WIDTH = 256;
   localparam int SCREEN_HEIGHT = 224;
   localparam int PLANE_BYTES = 8192;      // power of two
   localparam int NUM_PLANES = 3;
   localparam int ROW_PIXELS = 32;
   localparam int LARGE_LINE_BASE = 225;
   localparam int SMALL_LINE_BASE = 241;

   localparam int ADDR_W = $clog2(PLANE_BYTES);
   localparam int BANK_ADDR_W = ADDR_W - 2;
   localparam int BANK_DEPTH = PLANE_BYTES / 4;
   localparam int IDX_W = $clog2(ROW_PIXELS);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   // one byte from each of the four banks of each plane
   typedef logic [NUM_PLANES-1:0][3:0][7:0] plane_bytes_type;

   // a row handed to the pixel emitter, pens in screen column order
   typedef struct packed {
      logic [NUM_PLANES-1:0][ROW_PIXELS-1:0] pens;
      logic [7:0] x;
      logic [7:0] line;
      logic [3:0] pal;
   } row_type;

   // banks are selected by address bits 5 and 3, so the row bytes at
   // +0, +8, +32 and +40 all land in different banks at one bank address
   function automatic logic [1:0] bank_sel(input logic [ADDR_W-1:0] addr);
      return {addr[5], addr[3]};
   endfunction

   function automatic logic [BANK_ADDR_W-1:0] bank_addr(input logic [ADDR_W-1:0] addr);
      return {addr[ADDR_W-1:6], addr[4], addr[2:0]};
   endfunction

   // index of the lowest set bit
   function automatic logic [IDX_W-1:0] low_index(input logic [ROW_PIXELS-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = ROW_PIXELS - 1; i >= 0; i--) begin
         if (vec[i]) idx = IDX_W'(i);
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

@@ src/srr_rom.sv @@
// banked bitplane rom: byte writes, one registered row read across all banks
`default_nettype none

module srr_rom (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [1:0]                         wr_plane,
   input  logic [srr_pkg::ADDR_W-1:0]         wr_addr,
   input  logic [7:0]                         wr_data,
   input  logic                               rd_en,
   input  logic [srr_pkg::BANK_ADDR_W-1:0]    rd_addr,
   output srr_pkg::plane_bytes_type           rd_data
);
   import srr_pkg::*;

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      for (genvar b = 0; b < 4; b++) begin : g_bank
         logic [7:0] mem_ff [BANK_DEPTH];
         logic [7:0] q_ff;

         always_ff @(posedge clock) begin
            if (wr_en && wr_plane == 2'(p) && bank_sel(wr_addr) == 2'(b)) begin
               mem_ff[bank_addr(wr_addr)] <= wr_data;
            end
            if (rd_en) begin
               q_ff <= mem_ff[rd_addr];
            end
         end

         assign rd_data[p][b] = q_ff;
      end
   end

endmodule

`default_nettype wire

@@ src/srr_emit.sv @@
// pixel emitter: walks the set pens of one row, one pixel per cycle
`default_nettype none

module srr_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  srr_pkg::row_type  row,
   output logic              can_load,
   output logic              rsp_valid,
   output logic [7:0]        rsp_pixel_x,
   output logic [7:0]        rsp_pixel_y,
   output logic [6:0]        rsp_pixel_color,
   output logic              rsp_last
);
   import srr_pkg::*;

   logic [NUM_PLANES-1:0][ROW_PIXELS-1:0] pens_ff;
   logic [ROW_PIXELS-1:0] mask_ff, mask_in;
   logic [7:0] x_ff, line_ff;
   logic [3:0] pal_ff;
   logic valid_ff;
   logic [7:0] sx_ff, sy_ff;
   logic [6:0] color_ff;
   logic last_ff;

   logic [ROW_PIXELS-1:0] pick, rest, new_mask;
   logic [IDX_W-1:0] idx;
   logic [2:0] pen;

   always_comb begin
      pick = mask_ff & (~mask_ff + ROW_PIXELS'(1));
      rest = mask_ff & ~pick;
      idx = low_index(mask_ff);
      pen = {pens_ff[0][idx], pens_ff[1][idx], pens_ff[2][idx]};
      for (int k = 0; k < ROW_PIXELS; k++) begin
         new_mask[k] = (row.pens[0][k] | row.pens[1][k] | row.pens[2][k]) &&
                       ({1'b0, 8'(row.x + 8'(k))} < 9'(SCREEN_WIDTH));
      end
      mask_in = load ? new_mask : rest;
      can_load = (rest == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         valid_ff <= |mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (|mask_ff) begin
         sx_ff <= x_ff + 8'(idx);
         sy_ff <= line_ff;
         color_ff <= {pal_ff, pen};
         last_ff <= (rest == '0);
      end
      if (load) begin
         pens_ff <= row.pens;
         x_ff <= row.x;
         line_ff <= row.line;
         pal_ff <= row.pal;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_pixel_x = sx_ff;
   assign rsp_pixel_y = sy_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_last = last_ff;

endmodule

`default_nettype wire

@@ src/sprite_row_rasterizer.sv @@
// top level of the sprite row rasterizer
`default_nettype none

// sprite row rasterizer
// input channel: an item is taken on a rising edge with start high and busy
// low. req_cmd selects a rom byte load (req_plane, req_rom_addr, req_rom_byte)
// or a draw of one sprite row (req_code_byte, req_attr_byte, req_x_pos,
// req_y_pos, req_row). loads to plane 3 are ignored.
// result channel: rsp_valid marks one pixel for exactly one cycle; the
// receiver cannot hold results off. rsp_last flags the final pixel of a row.
// a draw reads the rom as it is taken, waits in the read stage until the
// emitter can load it, then shows its first pixel from the emitter output
// registers. throughput: one pixel per cycle; a row holds the emitter until
// its pixels (at most 32) are out, and the next row is taken while it runs.
// loads and rows that give no pixel are taken every cycle unless busy is up.
// busy rises only when a row waits in the read stage while the emitter still
// has more than one pixel to send.
// reset clears the pipeline valid state only; rom contents are undefined
// until loaded and there is no clearing pass.
module sprite_row_rasterizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [1:0]  req_plane,
   input  logic [12:0] req_rom_addr,
   input  logic [7:0]  req_rom_byte,
   input  logic [7:0]  req_code_byte,
   input  logic [7:0]  req_attr_byte,
   input  logic [7:0]  req_x_pos,
   input  logic [7:0]  req_y_pos,
   input  logic [4:0]  req_row,
   output logic        rsp_valid,
   output logic [7:0]  rsp_pixel_x,
   output logic [7:0]  rsp_pixel_y,
   output logic [6:0]  rsp_pixel_color,
   output logic        rsp_last
);
   import srr_pkg::*;

   // accept and request decode
   logic accept, is_draw, is_large;
   logic [2:0] row_off;
   logic [2:0] r_lo;
   logic [ADDR_W-1:0] base;
   logic [4:0] eff_row;
   logic [9:0] line10;
   logic visible;

   // read stage
   logic a_valid_ff, a_valid_in;
   logic a_large_ff, a_hflip_ff, a_sel_ff;
   logic [7:0] a_x_ff, a_line_ff;
   logic [3:0] a_pal_ff;

   plane_bytes_type rd_data;
   row_type row;
   logic advance, can_load;

   assign accept = start && !busy;
   assign is_draw = (req_cmd == CMD_DRAW);
   assign is_large = req_code_byte[7];

   always_comb begin
      r_lo = req_row[2:0];
      // large rows step 16 bytes at row 8 and 64 at row 16; small only the first
      row_off = 3'(req_row[3]) << 1;
      if (is_large) begin
         base = ADDR_W'({req_code_byte[6:0], 7'b0}) + ADDR_W'({req_row[4], row_off, r_lo});
         eff_row = req_row;
         line10 = 10'(LARGE_LINE_BASE) - {2'b0, req_y_pos} + {5'b0, eff_row};
         visible = !line10[9] && (line10 < 10'(SCREEN_HEIGHT));
      end else begin
         base = ADDR_W'({req_code_byte[6:0], 5'b0}) + ADDR_W'({row_off, r_lo});
         eff_row = req_attr_byte[7] ? (5'd15 - {1'b0, req_row[3:0]}) : {1'b0, req_row[3:0]};
         line10 = 10'(SMALL_LINE_BASE) - {2'b0, req_y_pos} + {5'b0, eff_row};
         // small sprites have only sixteen rows
         visible = !line10[9] && (line10 < 10'(SCREEN_HEIGHT)) && !req_row[4];
      end
   end

   srr_rom u_rom (
      .clock   (clock),
      .wr_en   (accept && !is_draw),
      .wr_plane(req_plane),
      .wr_addr (ADDR_W'(req_rom_addr)),
      .wr_data (req_rom_byte),
      .rd_en   (accept && is_draw),
      .rd_addr (bank_addr(base)),
      .rd_data (rd_data)
   );

   // read stage hands its row on once the emitter is idle or on its final pixel
   assign advance = a_valid_ff && can_load;
   assign busy = a_valid_ff && !can_load;

   always_comb begin
      if (accept && is_draw) begin
         a_valid_in = visible;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_draw) begin
         a_large_ff <= is_large;
         a_hflip_ff <= req_attr_byte[6];
         a_sel_ff <= req_code_byte[0];
         a_x_ff <= req_x_pos;
         a_line_ff <= line10[7:0];
         a_pal_ff <= req_attr_byte[3:0];
      end
   end

   // put the fetched bytes in screen column order
   always_comb begin
      logic [31:0] bm32;
      logic [15:0] bm16;
      row.x = a_x_ff;
      row.line = a_line_ff;
      row.pal = a_pal_ff;
      for (int p = 0; p < NUM_PLANES; p++) begin
         bm32 = {rd_data[p][0], rd_data[p][1], rd_data[p][2], rd_data[p][3]};
         bm16 = {rd_data[p][{a_sel_ff, 1'b0}], rd_data[p][{a_sel_ff, 1'b1}]};
         for (int k = 0; k < ROW_PIXELS; k++) begin
            if (a_large_ff) begin
               row.pens[p][k] = bm32[31-k];
            end else if (k < 16) begin
               row.pens[p][k] = a_hflip_ff ? bm16[k] : bm16[15-k];
            end else begin
               row.pens[p][k] = 1'b0;
            end
         end
      end
   end

   srr_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (advance),
      .row            (row),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   // a row's pixels come out on consecutive cycles
   a_row_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("pixel row broken off before its last pixel");

   // every pixel of one row sits on the same line
   a_row_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_pixel_y == $past(rsp_pixel_y))
      else $error("line changed inside a pixel row");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel out right after reset");

   // with the read stage empty a load leaves the block free
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cmd == CMD_LOAD && !a_valid_ff |=> !busy)
      else $error("load made the block busy");
`endif

endmodule

`default_nettype wire
